// ----- rtl/core/bir_pkg.sv -----
// Package for the bilinear image resampler: sizes, command codes and shared types.
// No dependencies.
package bir_pkg;
  localparam int MaxInDim = 64;
  localparam int MaxOutDim = 1024;
  localparam int SampleBits = 16;
  localparam int IdxBits = $clog2(MaxInDim);
  localparam int HalfDepth = MaxInDim * MaxInDim / 4;
  localparam int BankBits = $clog2(HalfDepth);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_REQUEST = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_IN_HEIGHT = 3'd0,
    REG_IN_WIDTH = 3'd1,
    REG_OUT_HEIGHT = 3'd2,
    REG_OUT_WIDTH = 3'd3,
    REG_CORNER_MODE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [IdxBits-1:0] lo;
    logic [IdxBits-1:0] hi;
    logic [16:0] w;
  } axis_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_RUN
  } sc_state_t;
endpackage

// ----- rtl/core/bir_scale_div.sv -----
// Serial restoring divider that recomputes one Q16.16 scale after a configuration write.
// Depends on bir_pkg.
module bir_scale_div
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [22:0] dividend,
  input  logic [10:0] divisor,
  output logic [31:0] quotient,
  output logic        done
);
  sc_state_t state, state_next;
  logic [4:0] count;
  logic [22:0] quo;
  logic [11:0] rem;
  logic [11:0] trial;

  always_comb begin
    unique case (state)
      SC_IDLE: state_next = go ? SC_RUN : SC_IDLE;
      SC_RUN: state_next = (count == 5'd0 && !go) ? SC_IDLE : SC_RUN;
      default: state_next = SC_IDLE;
    endcase
  end

  always_comb begin
    trial = {rem[10:0], quo[22]};
    done = (state == SC_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      count <= '0;
      quotient <= '0;
    end else begin
      state <= state_next;
      if (go) begin
        count <= 5'd23;
        quo <= dividend;
        rem <= '0;
      end else if (state == SC_RUN && count != 5'd0) begin
        count <= count - 5'd1;
        if (trial >= {1'b0, divisor}) begin
          rem <= trial - {1'b0, divisor};
          quo <= {quo[21:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[21:0], 1'b0};
        end
        if (count == 5'd1) begin
          quotient <= {9'd0, quo[21:0], (trial >= {1'b0, divisor})};
        end
      end
    end
  end
endmodule

// ----- rtl/core/bilinear_image_resampler.sv -----
// Bilinear image resampler top level with a four-bank frame store and blend pipeline.
// Depends on bir_pkg and bir_scale_div.
// Takes one request per cycle while busy is low; pixels pass through a registered blend pipeline.
// The four parity banks of the frame store give all four neighbors in one read.
// The receiver cannot stall. Busy is high while cfg_valid is high, and after rst or a write
// to register index 0 to 4 while both scales are recomputed by the serial divider.
module bilinear_image_resampler
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [15:0] sample,
  input  logic [9:0]  out_row,
  input  logic [9:0]  out_col,
  output logic        strobe,
  output logic [15:0] pixel,
  output logic [9:0]  res_row,
  output logic [9:0]  res_col,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  logic [6:0] in_height, in_width;
  logic [10:0] out_height, out_width;
  logic corner_mode;
  logic [31:0] row_scale, col_scale;

  logic [6:0] eff_ih, eff_iw;
  logic [10:0] eff_oh, eff_ow;
  logic cfg_we;
  logic recalc;
  logic [1:0] phase;
  logic div_go, div_done;
  logic [22:0] div_num;
  logic [10:0] div_den;
  logic [31:0] div_q;
  logic div_zero;

  function automatic logic [6:0] eff_in(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'(MaxInDim)) return 7'(MaxInDim);
    return v;
  endfunction

  function automatic logic [10:0] eff_out(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if (v > 11'(MaxOutDim)) return 11'(MaxOutDim);
    return v;
  endfunction

  assign eff_ih = eff_in(in_height);
  assign eff_iw = eff_in(in_width);
  assign eff_oh = eff_out(out_height);
  assign eff_ow = eff_out(out_width);
  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_height <= 7'd64;
      in_width <= 7'd64;
      out_height <= 11'd64;
      out_width <= 11'd64;
      corner_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_HEIGHT: in_height <= cfg_data[6:0];
        REG_IN_WIDTH: in_width <= cfg_data[6:0];
        REG_OUT_HEIGHT: out_height <= cfg_data;
        REG_OUT_WIDTH: out_width <= cfg_data;
        REG_CORNER_MODE: corner_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Phases: 0 idle, 1 dividing rows, 2 dividing columns.
  always_comb begin
    logic [6:0] ein;
    logic [10:0] eout;
    ein = (phase == 2'd2) ? eff_iw : eff_ih;
    eout = (phase == 2'd2) ? eff_ow : eff_oh;
    if (corner_mode) begin
      div_num = {7'(ein - 7'd1), 16'd0};
      div_den = eout - 11'd1;
      div_zero = (eout == 11'd1);
    end else begin
      div_num = {ein, 16'd0};
      div_den = eout;
      div_zero = 1'b0;
    end
  end

  logic go_pend;
  always_ff @(posedge clk) begin
    if (rst) begin
      recalc <= 1'b1;
      phase <= 2'd0;
      go_pend <= 1'b0;
      row_scale <= '0;
      col_scale <= '0;
    end else begin
      go_pend <= 1'b0;
      if (cfg_we && (cfg_index <= REG_CORNER_MODE)) begin
        recalc <= 1'b1;
        phase <= 2'd0;
      end else if (recalc && phase == 2'd0) begin
        recalc <= 1'b0;
        phase <= 2'd1;
        go_pend <= 1'b1;
      end else if (phase != 2'd0 && !go_pend && div_done) begin
        if (phase == 2'd1) begin
          row_scale <= div_zero ? 32'd0 : div_q;
          phase <= 2'd2;
          go_pend <= 1'b1;
        end else begin
          col_scale <= div_zero ? 32'd0 : div_q;
          phase <= 2'd0;
        end
      end
    end
  end

  assign div_go = go_pend;

  bir_scale_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_num), .divisor(div_den),
    .quotient(div_q), .done(div_done)
  );

  assign busy = recalc || (phase != 2'd0) || cfg_valid;

  function automatic axis_t axis_map(input logic [9:0] i, input logic [31:0] scale,
                                     input logic [6:0] ein, input logic cm);
    logic [43:0] pos;
    logic [43:0] p;
    logic [27:0] idx;
    axis_t a;
    if (cm) begin
      pos = 44'(i) * 44'(scale);
    end else begin
      p = (44'({i, 1'b1}) * 44'(scale)) >> 1;
      pos = (p > 44'h8000) ? p - 44'h8000 : 44'd0;
    end
    idx = pos[43:16];
    a.w = {1'b0, pos[15:0]};
    if (idx > 28'(ein - 7'd1)) begin
      idx = 28'(ein - 7'd1);
      a.w = '0;
    end
    a.lo = idx[IdxBits-1:0];
    a.hi = (idx + 28'd1 > 28'(ein - 7'd1)) ? 6'(ein - 7'd1) : 6'(idx + 28'd1);
    return a;
  endfunction

  // Stage 1: positions and weights.
  logic accept;
  logic s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  axis_t ra, ca;
  logic [9:0] s1_r, s1_c, s2_r, s2_c, s3_r, s3_c, s4_r, s4_c, s5_r, s5_c, s6_r, s6_c;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (s1_v || accept) begin
      ra <= axis_map(out_row, row_scale, eff_ih, corner_mode);
      ca <= axis_map(out_col, col_scale, eff_iw, corner_mode);
      s1_r <= out_row;
      s1_c <= out_col;
    end
  end

  // Frame store: four banks by row and column parity.
  logic [15:0] bank0 [HalfDepth];
  logic [15:0] bank1 [HalfDepth];
  logic [15:0] bank2 [HalfDepth];
  logic [15:0] bank3 [HalfDepth];
  logic [15:0] rd [4];
  logic [BankBits-1:0] wa;
  logic [1:0] wb;
  logic wr_en;
  logic [BankBits-1:0] ra_b [4];
  logic [1:0] s2_sel_r, s2_sel_c;
  logic [16:0] s2_wr, s2_wc;

  assign wr_en = accept && (cmd == CMD_WRITE);
  assign wa = {in_row[IdxBits-1:1], in_col[IdxBits-1:1]};
  assign wb = {in_row[0], in_col[0]};

  always_comb begin
    logic [IdxBits-1:0] re, ro, ce, co;
    re = ra.lo[0] ? ra.hi : ra.lo;
    ro = ra.lo[0] ? ra.lo : ra.hi;
    ce = ca.lo[0] ? ca.hi : ca.lo;
    co = ca.lo[0] ? ca.lo : ca.hi;
    ra_b[0] = {re[IdxBits-1:1], ce[IdxBits-1:1]};
    ra_b[1] = {re[IdxBits-1:1], co[IdxBits-1:1]};
    ra_b[2] = {ro[IdxBits-1:1], ce[IdxBits-1:1]};
    ra_b[3] = {ro[IdxBits-1:1], co[IdxBits-1:1]};
  end

  // A write accepted in the same cycle belongs to a later request, so the read keeps the old sample.
  always_ff @(posedge clk) begin
    if (wr_en && wb == 2'd0) bank0[wa] <= sample;
    if (wr_en && wb == 2'd1) bank1[wa] <= sample;
    if (wr_en && wb == 2'd2) bank2[wa] <= sample;
    if (wr_en && wb == 2'd3) bank3[wa] <= sample;
    rd[0] <= bank0[ra_b[0]];
    rd[1] <= bank1[ra_b[1]];
    rd[2] <= bank2[ra_b[2]];
    rd[3] <= bank3[ra_b[3]];
    s2_sel_r <= {ra.lo[0], (ra.lo == ra.hi)};
    s2_sel_c <= {ca.lo[0], (ca.lo == ca.hi)};
    s2_wr <= ra.w;
    s2_wc <= ca.w;
    s2_r <= s1_r;
    s2_c <= s1_c;
  end

  // Stage 3: select the four samples into corner order.
  logic [15:0] s00, s01, s10, s11;
  logic [16:0] s3_wr, s3_wc;
  always_ff @(posedge clk) begin
    logic [15:0] e0, e1, o0, o1, t0, t1, b0, b1;
    e0 = s2_sel_c[1] ? rd[1] : rd[0];
    e1 = s2_sel_c[1] ? rd[0] : rd[1];
    o0 = s2_sel_c[1] ? rd[3] : rd[2];
    o1 = s2_sel_c[1] ? rd[2] : rd[3];
    if (s2_sel_c[0]) begin
      e1 = e0;
      o1 = o0;
    end
    t0 = s2_sel_r[1] ? o0 : e0;
    t1 = s2_sel_r[1] ? o1 : e1;
    b0 = s2_sel_r[1] ? e0 : o0;
    b1 = s2_sel_r[1] ? e1 : o1;
    if (s2_sel_r[0]) begin
      b0 = t0;
      b1 = t1;
    end
    s00 <= t0;
    s01 <= t1;
    s10 <= b0;
    s11 <= b1;
    s3_wr <= s2_wr;
    s3_wc <= s2_wc;
    s3_r <= s2_r;
    s3_c <= s2_c;
  end

  // Stage 4: column products.
  logic [32:0] p00, p01, p10, p11;
  logic [16:0] s4_wr;
  always_ff @(posedge clk) begin
    p00 <= 33'(s00) * 33'(17'h10000 - s3_wc);
    p01 <= 33'(s01) * 33'(s3_wc);
    p10 <= 33'(s10) * 33'(17'h10000 - s3_wc);
    p11 <= 33'(s11) * 33'(s3_wc);
    s4_wr <= s3_wr;
    s4_r <= s3_r;
    s4_c <= s3_c;
  end

  // Stage 5: row products, split into the top-row and bottom-row terms of the blend.
  logic [32:0] top, bot;
  assign top = p00 + p01;
  assign bot = p10 + p11;
  logic [49:0] a_t, a_b;
  always_ff @(posedge clk) begin
    a_t <= 50'(top) * 50'(17'h10000 - s4_wr);
    a_b <= 50'(bot) * 50'(s4_wr);
    s5_r <= s4_r;
    s5_c <= s4_c;
  end

  // Stage 6: sum, round and saturate.
  logic [50:0] acc;
  logic [18:0] pix;
  assign acc = 51'(a_t) + 51'(a_b) + 51'h80000000;
  assign pix = acc[50:32];
  always_ff @(posedge clk) begin
    pixel <= (pix > 19'hFFFF) ? 16'hFFFF : pix[15:0];
    res_row <= s5_r;
    res_col <= s5_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else begin
      s1_v <= accept && (cmd == CMD_REQUEST);
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end
  assign strobe = s6_v;
endmodule

// ----- rtl/core/bir_checker.sv -----
// Port-level checker for the bilinear image resampler, bound to the top level.
// Depends on bir_pkg.
module bir_checker
  import bir_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       cmd,
  input logic [9:0] out_row,
  input logic [9:0] out_col,
  input logic       strobe,
  input logic [9:0] res_row,
  input logic [9:0] res_col,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [2:0] cfg_index
);
  a_strobe_follows_request: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy && cmd == CMD_REQUEST, 6))
    else $error("strobe without request");
  a_request_gets_strobe: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_REQUEST) |-> ##6 strobe)
    else $error("request lost");
  a_row_tag: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (res_row == $past(out_row, 6) && res_col == $past(out_col, 6)))
    else $error("result tag mismatch");
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && cfg_index <= REG_CORNER_MODE) |=> busy)
    else $error("not busy after configuration");
endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
  .out_row(out_row), .out_col(out_col), .strobe(strobe),
  .res_row(res_row), .res_col(res_col), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
  .cfg_index(cfg_index)
);

// ----- tb/bilinear_image_resampler_test.sv -----
// Self-checking testbench for the bilinear image resampler: fills the part of the frame store
// that requests read, then drives write and pixel requests under several size settings.
// Depends on bir_pkg and the bilinear_image_resampler top level.
`timescale 1ns / 1ps

class resample_scoreboard;
  typedef struct {
    logic [15:0] pixel;
    logic [9:0]  row;
    logic [9:0]  col;
  } pixel_t;

  logic [15:0] plane [bir_pkg::MaxInDim * bir_pkg::MaxInDim];
  int unsigned in_height = 64, in_width = 64, out_height = 64, out_width = 64;
  bit          corner_mode = 0;
  longint unsigned row_scale, col_scale;
  pixel_t      pending_pixels[$];
  int          errors = 0;

  function new();
    rescale();
  endfunction

  function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function longint unsigned make_scale(int unsigned in_raw, int unsigned out_raw);
    longint unsigned in_d, out_d;
    in_d = clamp_dim(in_raw, bir_pkg::MaxInDim);
    out_d = clamp_dim(out_raw, bir_pkg::MaxOutDim);
    if (corner_mode) begin
      if (out_d <= 1) return 0;
      return ((in_d - 1) << 16) / (out_d - 1);
    end
    return (in_d << 16) / out_d;
  endfunction

  function void rescale();
    row_scale = make_scale(in_height, out_height);
    col_scale = make_scale(in_width, out_width);
  endfunction

  function void write_register(logic [2:0] index, logic [10:0] data);
    case (index)
      bir_pkg::REG_IN_HEIGHT:   in_height = 32'(data[6:0]);
      bir_pkg::REG_IN_WIDTH:    in_width = 32'(data[6:0]);
      bir_pkg::REG_OUT_HEIGHT:  out_height = 32'(data);
      bir_pkg::REG_OUT_WIDTH:   out_width = 32'(data);
      bir_pkg::REG_CORNER_MODE: corner_mode = data[0];
      default: return;
    endcase
    rescale();
  endfunction

  function void source_axis(int unsigned i, int unsigned in_raw, longint unsigned scale,
                            output int unsigned lo, output int unsigned hi,
                            output longint unsigned w);
    longint unsigned in_d, p, pos, idx;
    in_d = clamp_dim(in_raw, bir_pkg::MaxInDim);
    if (corner_mode) begin
      pos = i * scale;
    end else begin
      p = ((2 * longint'(i) + 1) * scale) >> 1;
      pos = (p > 'h8000) ? p - 'h8000 : 0;
    end
    idx = pos >> 16;
    w = pos & 'hFFFF;
    if (idx > in_d - 1) begin
      idx = in_d - 1;
      w = 0;
    end
    lo = 32'(idx);
    hi = 32'((idx + 1 > in_d - 1) ? in_d - 1 : idx + 1);
  endfunction

  function void note_request(bir_pkg::cmd_t cmd, logic [5:0] in_row, logic [5:0] in_col,
                             logic [15:0] sample, logic [9:0] out_row, logic [9:0] out_col);
    int unsigned r0, r1, c0, c1;
    longint unsigned wr, wc, top, bot, acc, pix;
    pixel_t e;
    if (cmd == bir_pkg::CMD_WRITE) begin
      plane[in_row * bir_pkg::MaxInDim + in_col] = sample;
      return;
    end
    source_axis(out_row, in_height, row_scale, r0, r1, wr);
    source_axis(out_col, in_width, col_scale, c0, c1, wc);
    top = plane[r0 * bir_pkg::MaxInDim + c0] * (65536 - wc) +
          plane[r0 * bir_pkg::MaxInDim + c1] * wc;
    bot = plane[r1 * bir_pkg::MaxInDim + c0] * (65536 - wc) +
          plane[r1 * bir_pkg::MaxInDim + c1] * wc;
    acc = top * (65536 - wr) + bot * wr;
    pix = (acc + 64'h8000_0000) >> 32;
    if (pix > 65535) pix = 65535;
    e.pixel = pix[15:0];
    e.row = out_row;
    e.col = out_col;
    pending_pixels.push_back(e);
  endfunction

  function void check_pixel(logic [15:0] pixel, logic [9:0] row, logic [9:0] col);
    pixel_t e;
    if (pending_pixels.size() == 0) begin
      $error("unexpected pixel %0d at row %0d col %0d", pixel, row, col);
      errors++;
      return;
    end
    e = pending_pixels.pop_front();
    if (pixel !== e.pixel) begin
      $error("pixel: expected %0d, got %0d", e.pixel, pixel);
      errors++;
    end
    if (row !== e.row) begin
      $error("res_row: expected %0d, got %0d", e.row, row);
      errors++;
    end
    if (col !== e.col) begin
      $error("res_col: expected %0d, got %0d", e.col, col);
      errors++;
    end
  endfunction
endclass

module bilinear_image_resampler_test;
  import bir_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int FillDim = 8;
  localparam logic [2:0] UnusedRegIdx = 3'd7;
  localparam logic [2:0] SpareRegIdx = 3'd5;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  cmd_t        cmd = CMD_WRITE;
  logic [5:0]  in_row = 0;
  logic [5:0]  in_col = 0;
  logic [15:0] sample = 0;
  logic [9:0]  out_row = 0;
  logic [9:0]  out_col = 0;
  logic        strobe;
  logic [15:0] pixel;
  logic [9:0]  res_row;
  logic [9:0]  res_col;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 0;
  logic [10:0] cfg_data = 0;

  resample_scoreboard sb = new();
  int unsigned cycles = 0;
  int          burst_left = 0;
  bit          no_gaps = 0;

  bilinear_image_resampler u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .in_row(in_row), .in_col(in_col), .sample(sample), .out_row(out_row),
    .out_col(out_col), .strobe(strobe), .pixel(pixel), .res_row(res_row),
    .res_col(res_col), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_pixel(pixel, res_row, res_col);
  end

  task automatic send(cmd_t c, logic [5:0] ir, logic [5:0] ic, logic [15:0] s,
                      logic [9:0] orow, logic [9:0] ocol);
    int gap;
    @(negedge clk);
    start = 1;
    cmd = c;
    in_row = ir;
    in_col = ic;
    sample = s;
    out_row = orow;
    out_col = ocol;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(c, ir, ic, s, orow, ocol);
    if (no_gaps) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk);
      start = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic write_sample(logic [5:0] r, logic [5:0] c, logic [15:0] s);
    send(CMD_WRITE, r, c, s, 10'($urandom), 10'($urandom));
  endtask

  task automatic request_pixel(logic [9:0] r, logic [9:0] c);
    send(CMD_REQUEST, 6'($urandom), 6'($urandom), 16'($urandom), r, c);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [10:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = index;
    cfg_data = data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_register(index, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic configure(logic [10:0] ih, logic [10:0] iw, logic [10:0] oh,
                           logic [10:0] ow, logic cm);
    drain();
    write_register(REG_IN_HEIGHT, ih);
    write_register(REG_IN_WIDTH, iw);
    write_register(REG_OUT_HEIGHT, oh);
    write_register(REG_OUT_WIDTH, ow);
    write_register(REG_CORNER_MODE, {10'd0, cm});
  endtask

  task automatic random_traffic(int count);
    int unsigned oh, ow;
    for (int k = 0; k < count; k++) begin
      oh = sb.clamp_dim(sb.out_height, MaxOutDim);
      ow = sb.clamp_dim(sb.out_width, MaxOutDim);
      if ($urandom_range(0, 4) == 0)
        write_sample(6'($urandom), 6'($urandom), 16'($urandom));
      else if ($urandom_range(0, 9) == 0)
        request_pixel(10'($urandom), 10'($urandom));
      else
        request_pixel(10'($urandom_range(0, oh - 1)), 10'($urandom_range(0, ow - 1)));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Requests only read the first row in full and the top-left block of the plane.
    configure(11'(FillDim), 11'(FillDim), 11'd64, 11'd64, 1'b0);
    no_gaps = 1;
    for (int c = 0; c < MaxInDim; c++)
      write_sample(6'd0, 6'(c), 16'($urandom));
    for (int r = 1; r < FillDim; r++)
      for (int c = 0; c < FillDim; c++)
        write_sample(6'(r), 6'(c), 16'($urandom));
    no_gaps = 0;

    write_sample(6'd0, 6'd0, 16'h0000);
    write_sample(6'd7, 6'd7, 16'hFFFF);
    write_sample(6'd0, 6'd7, 16'hFFFF);
    write_sample(6'd7, 6'd0, 16'h0000);
    write_sample(6'd1, 6'd1, 16'hFFFF);
    request_pixel(10'd0, 10'd0);
    request_pixel(10'd63, 10'd63);
    request_pixel(10'd0, 10'd63);
    request_pixel(10'd1023, 10'd1023);
    request_pixel(10'd1023, 10'd0);
    request_pixel(10'd64, 10'd512);
    request_pixel(10'd31, 10'd32);
    random_traffic(30);

    configure(11'd1, 11'd1, 11'd1, 11'd1, 1'b1);
    request_pixel(10'd0, 10'd0);
    request_pixel(10'd1023, 10'd1023);
    random_traffic(15);

    configure(11'd1, 11'd64, 11'd1024, 11'd1024, 1'b1);
    request_pixel(10'd0, 10'd0);
    request_pixel(10'd1023, 10'd1023);
    request_pixel(10'd512, 10'd511);
    random_traffic(30);

    configure(11'(FillDim), 11'(FillDim), 11'd1024, 11'd1024, 1'b0);
    request_pixel(10'd1023, 10'd0);
    random_traffic(30);
    drain();
    random_traffic(20);

    configure(11'd0, 11'h7FF, 11'd0, 11'h7FF, 1'b0);
    request_pixel(10'd0, 10'd1023);
    random_traffic(20);

    configure(11'd3, 11'(FillDim), 11'd7, 11'd2, 1'b1);
    write_register(UnusedRegIdx, 11'h7FF);
    write_register(SpareRegIdx, 11'h001);
    random_traffic(25);

    for (int ph = 0; ph < 4; ph++) begin
      configure(11'($urandom_range(1, FillDim)), 11'($urandom_range(1, FillDim)),
                11'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                                : $urandom_range(1, 128)),
                11'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                                : $urandom_range(1, 128)),
                1'($urandom_range(0, 1)));
      no_gaps = (ph == 2);
      random_traffic(30);
      no_gaps = 0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_pixels.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
